FILE: sv/foi_pkg.sv
// package: shared types, register map and rounding helpers of the fractional integrator
`timescale 1ns / 1ps

package foi_pkg;

  // signed q16.16 sample / result word
  typedef logic signed [31:0] q16_t;

  // apb register map
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  // register reset values
  localparam logic [17:0] ALPHA_RST  = 18'd32768;
  localparam logic [31:0] GAIN_RST   = 32'd65536;
  localparam logic [6:0]  LENGTH_RST = 7'd64;

  // alpha saturates at 2.0 in q2.16
  localparam logic [17:0] ORDER_CLAMP = 18'd131072;

  // coefficient zero, 1.0 in q2.30
  localparam logic signed [32:0] ONE_Q30 = 33'sh0_4000_0000;

  // sequencer states
  typedef enum logic [3:0] {
    S_BSTART,
    S_BLOAD,
    S_BDIV,
    S_BMUL1,
    S_BRND,
    S_BMUL2,
    S_BWR,
    S_IDLE,
    S_GAIN,
    S_GRND,
    S_SUM,
    S_FIN
  } foi_state_t;

  // divide by 2^30, round half away from zero
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v + 66'sh2000_0000 - {65'd0, v[65]};
    return s[65:30];
  endfunction

  // divide by 2^16, round half away from zero
  function automatic logic signed [49:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v + 66'sh8000 - {65'd0, v[65]};
    return s[65:16];
  endfunction

endpackage

FILE: sv/foi_in_if.sv
// interface: input sample channel, one three-axis sample per beat
`timescale 1ns / 1ps

interface foi_in_if;
  import foi_pkg::*;

  logic valid;
  logic ready;
  q16_t sample_x;
  q16_t sample_y;
  q16_t sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

FILE: sv/foi_out_if.sv
// interface: result channel, one three-axis result per beat
`timescale 1ns / 1ps

interface foi_out_if;
  import foi_pkg::*;

  logic valid;
  logic ready;
  q16_t result_x;
  q16_t result_y;
  q16_t result_z;

  modport source (output valid, output result_x, output result_y, output result_z,
                  input ready);
  modport sink (input valid, input result_x, input result_y, input result_z,
                output ready);
endinterface

FILE: sv/fractional_order_integrator.sv
// top level: grunwald-letnikov fractional integrator over a memory of past results
`timescale 1ns / 1ps

// Three-axis fractional-order integrator. Each beat on in_chan carries one q16.16
// sample; one beat on out_chan returns gain*sample minus the coefficient-weighted
// sum of that axis's past results, saturated to 32 bits.
// Registers over apb: order alpha (index 0), input gain (index 1), history length
// (index 2). Writing alpha rebuilds the coefficient memory.
// Coefficient build: runs after reset and after every alpha write; each
// coefficient takes a 31-step reciprocal divider and two multiplies, and
// in_chan.ready stays low for the whole pass.
// Item flow: an accepted sample is scaled by the gain (S_GAIN), rounded (S_GRND),
// then summed against the history in S_SUM, where the history memory read port
// delivers one past result per cycle, and written back in S_FIN; a new sample is
// taken only after the previous one has been written back.
// The result sits in an output register: a stalled receiver does not stop the
// next sample being taken and summed; only its write-back waits for the
// register to drain.
// Reset empties the history (fill count zero) and restores the register defaults.
module fractional_order_integrator #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  foi_in_if.sink                     in_chan,
  foi_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [foi_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import foi_pkg::*;

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned RW  = AW + 1;
  localparam int unsigned NW  = FW + 17;
  localparam int unsigned SW  = 36 + AW;
  localparam int unsigned DW  = ((SW > 50) ? SW : 50) + 1;
  localparam int unsigned CW  = (FW > 7) ? FW : 7;

  // configuration registers
  logic [17:0] alpha_r;
  logic [31:0] gain_r;
  logic [6:0]  length_r;
  logic        cfg_wr;
  logic        alpha_wr;

  // sequencer
  foi_state_t state_r, state_nxt;
  logic       in_ready;
  logic       coef_we;
  logic       issue;
  logic       fin_fire;
  logic       sum_done;

  // build datapath
  logic [FW-1:0]          k_r;
  logic [4:0]             cnt_r;
  logic [30:0]            div_r;
  logic [RW-1:0]          rem_r;
  logic [RW-1:0]          trial;
  logic                   qbit;
  logic signed [32:0]     cprev_r;
  logic signed [32:0]     q_r;
  logic signed [NW-1:0]   num;
  logic [17:0]            alpha_c;
  logic signed [49:0]     cnew_full;

  // item datapath
  q16_t                   sample_r [3];
  logic [FW-1:0]          n_r;
  logic [FW-1:0]          len_r;
  logic [FW-1:0]          len_eff;
  logic [FW-1:0]          fill_r;
  logic [AW-1:0]          head_r;
  logic [AW-1:0]          head_nxt;
  logic [AW-1:0]          rd_ptr_r;
  logic                   v1_r;
  logic                   v2_r;
  logic signed [49:0]     gterm_r [3];
  logic signed [SW-1:0]   sum_r [3];
  logic signed [32:0]     mul_a [3];
  logic signed [32:0]     mul_b [3];
  logic signed [65:0]     prod_r [3];
  logic signed [DW-1:0]   diff [3];
  q16_t                   res_nxt [3];
  q16_t                   res_r [3];
  logic                   out_valid_r;
  logic [FW:0]            n_inc;

  // memories
  logic [32:0]            coef_mem [HISTORY_DEPTH];
  logic [95:0]            hist_mem [HISTORY_DEPTH];
  logic [32:0]            coef_rd_r;
  logic [95:0]            hist_rd_r;

  // apb write decode
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign alpha_wr = cfg_wr && (paddr[3:2] == REG_ALPHA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RST;
      gain_r   <= GAIN_RST;
      length_r <= LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ALPHA:  alpha_r  <= pwdata[17:0];
        REG_GAIN:   gain_r   <= pwdata;
        REG_LENGTH: length_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // apb read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_ALPHA:  prdata = {14'd0, alpha_r};
      REG_GAIN:   prdata = gain_r;
      REG_LENGTH: prdata = {25'd0, length_r};
      default:    prdata = 32'd0;
    endcase
  end

  // effective length, 1..HISTORY_DEPTH
  always_comb begin
    if (length_r == 7'd0) begin
      len_eff = FW'(1);
    end else if (CW'(length_r) > CW'(HISTORY_DEPTH)) begin
      len_eff = FW'(HISTORY_DEPTH);
    end else begin
      len_eff = FW'(length_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BSTART: state_nxt = S_BLOAD;
      S_BLOAD:  state_nxt = S_BDIV;
      S_BDIV:   if (cnt_r == 5'd30) state_nxt = S_BMUL1;
      S_BMUL1:  state_nxt = S_BRND;
      S_BRND:   state_nxt = S_BMUL2;
      S_BMUL2:  state_nxt = S_BWR;
      S_BWR: begin
        if (k_r == FW'(HISTORY_DEPTH - 1)) state_nxt = S_IDLE;
        else state_nxt = S_BLOAD;
      end
      S_IDLE:   if (in_chan.valid) state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_GRND;
      S_GRND:   state_nxt = S_SUM;
      S_SUM:    if (sum_done) state_nxt = S_FIN;
      S_FIN:    if (fin_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_BSTART;
    endcase
    if (alpha_wr) state_nxt = S_BSTART;
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    coef_we  = 1'b0;
    issue    = 1'b0;
    sum_done = 1'b0;
    fin_fire = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_BWR:  coef_we = 1'b1;
      S_SUM: begin
        issue    = (k_r < n_r);
        sum_done = !(k_r < n_r) && !v1_r && !v2_r;
      end
      S_FIN:  fin_fire = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BSTART;
    end else begin
      state_r <= state_nxt;
    end
  end

  // reciprocal divider step: (2^30 + k/2) / k, one quotient bit a cycle
  assign trial = {rem_r[RW-2:0], div_r[30]};
  assign qbit  = (trial >= RW'(k_r));

  // coefficient recurrence operands
  assign alpha_c   = (alpha_r > ORDER_CLAMP) ? ORDER_CLAMP : alpha_r;
  assign num       = NW'({1'b0, FW'(k_r - FW'(1)), 16'h0000}) - NW'(alpha_c);
  assign cnew_full = rnd16(prod_r[0]);

  // shared multipliers: gain, history terms, coefficient build
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_a[i] = $signed(coef_rd_r);
      mul_b[i] = 33'($signed(hist_rd_r[32*i +: 32]));
    end
    case (state_r)
      S_GAIN: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = $signed({1'b0, gain_r});
          mul_b[i] = 33'(sample_r[i]);
        end
      end
      S_BMUL1: begin
        mul_a[0] = cprev_r;
        mul_b[0] = $signed({2'b00, div_r});
      end
      S_BMUL2: begin
        mul_a[0] = q_r;
        mul_b[0] = 33'(num);
      end
      default: ;
    endcase
  end

  // write-back value, saturated
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DW'(gterm_r[i]) - DW'(sum_r[i]);
      if ((&diff[i][DW-1:31]) || !(|diff[i][DW-1:31])) begin
        res_nxt[i] = diff[i][31:0];
      end else if (diff[i][DW-1]) begin
        res_nxt[i] = 32'sh8000_0000;
      end else begin
        res_nxt[i] = 32'sh7fff_ffff;
      end
    end
  end

  assign head_nxt = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign n_inc    = {1'b0, n_r} + (FW + 1)'(1);

  // datapath registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= mul_a[i] * mul_b[i];
    end
    unique case (state_r)
      S_BSTART: begin
        k_r     <= FW'(1);
        cprev_r <= ONE_Q30;
      end
      S_BLOAD: begin
        div_r <= 31'h4000_0000 + 31'(k_r >> 1);
        rem_r <= '0;
        cnt_r <= 5'd0;
      end
      S_BDIV: begin
        rem_r <= qbit ? trial - RW'(k_r) : trial;
        div_r <= {div_r[29:0], qbit};
        cnt_r <= cnt_r + 5'd1;
      end
      S_BRND:  q_r <= 33'(rnd30(prod_r[0]));
      S_BWR: begin
        cprev_r <= cnew_full[32:0];
        k_r     <= k_r + FW'(1);
      end
      S_IDLE: begin
        sample_r[0] <= in_chan.sample_x;
        sample_r[1] <= in_chan.sample_y;
        sample_r[2] <= in_chan.sample_z;
        n_r         <= (fill_r < len_eff) ? fill_r : len_eff;
        len_r       <= len_eff;
      end
      S_GRND: begin
        for (int i = 0; i < 3; i++) begin
          gterm_r[i] <= rnd16(prod_r[i]);
          sum_r[i]   <= '0;
        end
        k_r      <= FW'(1);
        rd_ptr_r <= head_r;
      end
      S_SUM: begin
        if (issue) begin
          k_r      <= k_r + FW'(1);
          rd_ptr_r <= (rd_ptr_r == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_r - AW'(1);
        end
        if (v2_r) begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] + SW'(rnd30(prod_r[i]));
          end
        end
      end
      default: ;
    endcase
    if (fin_fire) begin
      res_r <= res_nxt;
    end
  end

  // control registers of the item path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (fin_fire) begin
        head_r      <= head_nxt;
        fill_r      <= (n_inc < {1'b0, len_r}) ? n_inc[FW-1:0] : len_r;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // coefficient memory, entry k holds ck in q2.30
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[k_r[AW-1:0]] <= cnew_full[32:0];
    end
    coef_rd_r <= coef_mem[k_r[AW-1:0]];
  end

  // history ring of past results, x in the low word
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      hist_mem[head_nxt] <= {res_nxt[2], res_nxt[1], res_nxt[0]};
    end
    hist_rd_r <= hist_mem[rd_ptr_r];
  end

  // result channel
  assign out_chan.valid    = out_valid_r;
  assign out_chan.result_x = res_r[0];
  assign out_chan.result_y = res_r[1];
  assign out_chan.result_z = res_r[2];

  // checks
  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> out_valid_r)
    else $error("write-back did not load the output register");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> (k_r <= n_r) || (k_r == FW'(1)))
    else $error("history read index ran past the term count");

  a_alpha_restart: assert property (@(posedge clk) disable iff (!rst_n)
    alpha_wr |=> state_r == S_BSTART)
    else $error("alpha write did not restart the coefficient build");

endmodule

FILE: bench/fractional_order_integrator_tb.sv
// testbench: fractional integrator checked beat by beat against a fixed-point predictor
`timescale 1ns / 1ps

module fractional_order_integrator_tb;
  import foi_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PHASES = 8;
  localparam int unsigned SAMPLES_PER_PHASE = 180;
  localparam int unsigned LONG_STALL = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } triple_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  foi_in_if sample_bus ();
  foi_out_if result_bus ();

  fractional_order_integrator #(
    .HISTORY_DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (sample_bus),
    .out_chan(result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // predictor state: registers, coefficient tables and per-axis history
  logic [17:0] alpha_cfg;
  logic [31:0] gain_cfg;
  logic [6:0] length_cfg;
  longint gl_coeff [DEPTH];
  longint recip_q30 [DEPTH];
  q16_t history [3][DEPTH];
  int unsigned head_ptr;
  int unsigned fill_level;

  triple_t pending_samples [$];
  triple_t expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned long_stall_cycles = 0;
  bit long_stall_req = 1'b0;
  bit no_idle = 1'b0;

  // divide by 2^s, half away from zero
  function automatic longint round_away(longint v, int unsigned s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // grunwald-letnikov weights from alpha, clamped at 2.0
  function automatic void build_coeffs();
    longint a;
    longint q;
    longint num;
    a = (alpha_cfg > ORDER_CLAMP) ? longint'(ORDER_CLAMP) : longint'(alpha_cfg);
    gl_coeff[0] = longint'(ONE_Q30);
    for (int k = 1; k < DEPTH; k++) begin
      q = round_away(gl_coeff[k-1] * recip_q30[k], 30);
      num = longint'(k - 1) * 65536 - a;
      gl_coeff[k] = round_away(q * num, 16);
    end
  endfunction

  // gain term minus weighted past results of one axis, saturated
  function automatic q16_t axis_result(int axis, q16_t sample, int unsigned used);
    longint acc;
    longint total;
    longint diff;
    int unsigned idx;
    acc = round_away(longint'(gain_cfg) * longint'(sample), 16);
    total = 0;
    for (int unsigned k = 1; k < used; k++) begin
      idx = (head_ptr + DEPTH - (k - 1)) % DEPTH;
      total += round_away(gl_coeff[k] * longint'(history[axis][idx]), 30);
    end
    diff = acc - total;
    if (diff > longint'(Q16_MAX)) return Q16_MAX;
    if (diff < longint'(Q16_MIN)) return Q16_MIN;
    return q16_t'(diff[31:0]);
  endfunction

  // one sample in, one result out; result becomes newest history entry
  function automatic triple_t integrate_sample(triple_t s);
    int unsigned span;
    int unsigned used;
    triple_t r;
    span = (length_cfg == 0) ? 1 : ((length_cfg > DEPTH) ? DEPTH : length_cfg);
    used = (fill_level < span) ? fill_level : span;
    r.x = axis_result(0, s.x, used);
    r.y = axis_result(1, s.y, used);
    r.z = axis_result(2, s.z, used);
    head_ptr = (head_ptr + 1) % DEPTH;
    history[0][head_ptr] = r.x;
    history[1][head_ptr] = r.y;
    history[2][head_ptr] = r.z;
    fill_level = (used + 1 < span) ? used + 1 : span;
    return r;
  endfunction

  function automatic void compare_axis(string field, q16_t want, q16_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // mostly moderate values, some full-width words, some extremes
  function automatic q16_t random_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return q16_t'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    if (pick < 17) return q16_t'($urandom);
    case ($urandom_range(0, 4))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic void queue_sample(q16_t x, q16_t y, q16_t z);
    triple_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // apb write: setup then access, predictor updated at the write edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ALPHA: begin
        alpha_cfg = value[17:0];
        build_coeffs();
      end
      REG_GAIN: gain_cfg = value;
      REG_LENGTH: length_cfg = value[6:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // sample driver: one beat per pending entry, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      sample_bus.valid <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        expected_results.insert(expected_results.size(),
                                integrate_sample(pending_samples.pop_front()));
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (in_gap != 0) begin
          sample_bus.valid <= 1'b0;
          in_gap--;
        end else if (pending_samples.size() != 0) begin
          sample_bus.valid <= 1'b1;
          sample_bus.sample_x <= pending_samples[0].x;
          sample_bus.sample_y <= pending_samples[0].y;
          sample_bus.sample_z <= pending_samples[0].z;
          if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    triple_t want;
    if (rst_n) begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no sample outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_axis("result_x", want.x, result_bus.result_x);
          compare_axis("result_y", want.y, result_bus.result_y);
          compare_axis("result_z", want.z, result_bus.result_z);
        end
      end
      if (long_stall_req && long_stall_cycles < LONG_STALL) begin
        result_bus.ready <= 1'b0;
        long_stall_cycles++;
      end else if (out_gap != 0) begin
        result_bus.ready <= 1'b0;
        out_gap--;
      end else begin
        result_bus.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 3);
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [17:0] alpha_pick;
    logic [31:0] gain_pick;
    logic [6:0] length_pick;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample_x = '0;
    sample_bus.sample_y = '0;
    sample_bus.sample_z = '0;
    result_bus.ready = 1'b0;

    // predictor reset state
    alpha_cfg = ALPHA_RST;
    gain_cfg = GAIN_RST;
    length_cfg = LENGTH_RST;
    head_ptr = 0;
    fill_level = 0;
    recip_q30[0] = 0;
    for (int k = 1; k < DEPTH; k++) recip_q30[k] = (longint'(ONE_Q30) + k / 2) / k;
    for (int k = 0; k < DEPTH; k++) begin
      history[0][k] = '0;
      history[1][k] = '0;
      history[2][k] = '0;
    end
    build_coeffs();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: empty history first, then field extremes
    queue_sample(32'sd0, 32'sd0, 32'sd0);
    queue_sample(Q16_MAX, Q16_MIN, 32'sd1);
    queue_sample(Q16_MIN, Q16_MAX, -32'sd1);
    queue_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_0000);
    queue_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678);
    wait_drained();

    // shortened memory drops the older entries at once
    write_reg(REG_LENGTH, 32'd2);
    queue_sample(32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000);
    queue_sample(-32'sh0001_8000, 32'sh0004_0000, 32'sd0);
    wait_drained();

    // full gain saturates, alpha at 2.0, single history entry
    write_reg(REG_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_ALPHA, 32'(ORDER_CLAMP));
    write_reg(REG_LENGTH, 32'd1);
    queue_sample(Q16_MAX, Q16_MIN, 32'sd1);
    queue_sample(32'sh0000_8000, -32'sh0000_8000, 32'sd0);
    wait_drained();

    // alpha beyond 2.0 clamps, then zero length behaves as one
    write_reg(REG_ALPHA, 32'h0003_FFFF);
    write_reg(REG_GAIN, 32'(GAIN_RST));
    write_reg(REG_LENGTH, 32'd8);
    queue_sample(32'sh0001_0000, 32'sh0010_0000, -32'sh0002_0000);
    queue_sample(32'sh0003_0000, -32'sh0001_0000, 32'sh0000_4000);
    queue_sample(-32'sh0007_0000, 32'sh0000_0001, 32'sh0100_0000);
    wait_drained();
    write_reg(REG_LENGTH, 32'd0);
    queue_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    wait_drained();

    // unmapped register, alpha zero, length beyond the memory depth
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_LENGTH, 32'd127);
    queue_sample(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000);
    queue_sample(random_word(), random_word(), random_word());
    queue_sample(random_word(), random_word(), random_word());
    queue_sample(random_word(), random_word(), random_word());
    wait_drained();

    // random phases, each under its own register setting
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      alpha_pick = (phase == 1) ? 18'd0 :
                   (phase == 2) ? ORDER_CLAMP : 18'($urandom_range(0, ORDER_CLAMP));
      gain_pick = (phase == 3) ? 32'hFFFF_FFFF :
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
      length_pick = (phase == 4) ? 7'd1 :
                    (phase == 5) ? 7'd64 : 7'($urandom_range(1, DEPTH));
      write_reg(REG_ALPHA, 32'(alpha_pick));
      write_reg(REG_GAIN, gain_pick);
      write_reg(REG_LENGTH, 32'(length_pick));
      if (phase == PHASES - 1) no_idle = 1'b1;
      for (int unsigned i = 0; i < SAMPLES_PER_PHASE; i++) begin
        queue_sample(random_word(), random_word(), random_word());
      end
      // long receiver hold-off once samples are flowing, so the input backs up
      if (phase == 2) begin
        while (expected_results.size() == 0) @(posedge clk);
        long_stall_req = 1'b1;
      end
      wait_drained();
    end

    repeat (DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
